// ===== sv/fmpd_pkg.sv =====
// ----------------------------------------------------------------------------
// fmpd_pkg
// Shared widths, angle constants and pipeline types of the FM discriminator.
// ----------------------------------------------------------------------------
package fmpd_pkg;

	localparam int SAMPLE_W       = 16;
	localparam int MAG_W          = SAMPLE_W - 1;	// saturated magnitude
	localparam int DEN_W          = SAMPLE_W;	// |im| + |re|
	localparam int NUM_W          = 31;		// 65528 * |a - b|
	localparam int QUOT_W         = 16;		// quotient never exceeds 65528
	localparam int REM_W          = DEN_W;
	localparam int LOW_W          = QUOT_W;
	localparam int BITS_PER_STAGE = 2;
	localparam int DIV_STAGES     = QUOT_W / BITS_PER_STAGE;
	localparam int ANGLE_W        = QUOT_W + 1;

	localparam logic [NUM_W-1:0] ANG_NUM_SCALE = NUM_W'(8191 * 8);
	localparam logic signed [ANGLE_W-1:0] ANG_EIGHTH        = 17'sd8191;
	localparam logic signed [ANGLE_W-1:0] ANG_THREE_EIGHTHS = 17'sd24575;

	// {im negative, re negative}
	typedef enum logic [1:0] {
		QUAD_1 = 2'b00,
		QUAD_2 = 2'b01,
		QUAD_3 = 2'b11,
		QUAD_4 = 2'b10
	} fmpd_quad_t;

	typedef struct packed {
		logic       den_zero;
		logic       diff_neg;
		fmpd_quad_t quad;
	} fmpd_side_t;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		fmpd_side_t       side;
	} fmpd_div_req_t;

	typedef struct packed {
		logic [QUOT_W-1:0] quot;
		fmpd_side_t        side;
	} fmpd_div_rsp_t;

endpackage

// ===== sv/fmpd_divider.sv =====
// ----------------------------------------------------------------------------
// fmpd_divider
// Pipelined unsigned restoring divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
module fmpd_divider (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  req_valid,
	input  fmpd_pkg::fmpd_div_req_t req,
	output logic                  rsp_valid,
	output fmpd_pkg::fmpd_div_rsp_t rsp
);

	localparam int N = fmpd_pkg::DIV_STAGES;

	logic [fmpd_pkg::REM_W-1:0]  rem_s  [N];
	logic [fmpd_pkg::LOW_W-1:0]  low_s  [N];
	logic [fmpd_pkg::QUOT_W-1:0] quot_s [N];
	logic [fmpd_pkg::DEN_W-1:0]  den_s  [N];
	fmpd_pkg::fmpd_side_t        side_s [N];
	logic [N-1:0]                valid_s;

	logic [fmpd_pkg::REM_W-1:0]  rem_d  [N];
	logic [fmpd_pkg::LOW_W-1:0]  low_d  [N];
	logic [fmpd_pkg::QUOT_W-1:0] quot_d [N];

	always_comb begin
		logic [fmpd_pkg::REM_W-1:0]  r;
		logic [fmpd_pkg::LOW_W-1:0]  l;
		logic [fmpd_pkg::QUOT_W-1:0] q;
		logic [fmpd_pkg::DEN_W-1:0]  d;
		logic [fmpd_pkg::REM_W:0]    t;
		for (int k = 0; k < N; k++) begin
			if (k == 0) begin
				// quotient fits QUOT_W bits, so the top part is already below den
				r = fmpd_pkg::REM_W'(req.num[fmpd_pkg::NUM_W-1:fmpd_pkg::LOW_W]);
				l = req.num[fmpd_pkg::LOW_W-1:0];
				q = '0;
				d = req.den;
			end else begin
				r = rem_s[k-1];
				l = low_s[k-1];
				q = quot_s[k-1];
				d = den_s[k-1];
			end
			for (int j = 0; j < fmpd_pkg::BITS_PER_STAGE; j++) begin
				t = {r, l[fmpd_pkg::LOW_W-1]};
				l = {l[fmpd_pkg::LOW_W-2:0], 1'b0};
				if (t >= {1'b0, d}) begin
					t = t - {1'b0, d};
					q = {q[fmpd_pkg::QUOT_W-2:0], 1'b1};
				end else begin
					q = {q[fmpd_pkg::QUOT_W-2:0], 1'b0};
				end
				r = t[fmpd_pkg::REM_W-1:0];
			end
			rem_d[k]  = r;
			low_d[k]  = l;
			quot_d[k] = q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[N-2:0], req_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				rem_s[k]  <= rem_d[k];
				low_s[k]  <= low_d[k];
				quot_s[k] <= quot_d[k];
				if (k == 0) begin
					den_s[k]  <= req.den;
					side_s[k] <= req.side;
				end else begin
					den_s[k]  <= den_s[k-1];
					side_s[k] <= side_s[k-1];
				end
			end
		end
	end

	assign rsp_valid = valid_s[N-1];
	assign rsp.quot  = quot_s[N-1];
	assign rsp.side  = side_s[N-1];

endmodule

// ===== sv/fm_phase_discriminator.sv =====
// ----------------------------------------------------------------------------
// fm_phase_discriminator
// Polar FM discriminator: angle of x[n] * conj(x[n-1]), negated.
// ----------------------------------------------------------------------------
// Takes one complex sample per cycle and returns one phase_delta per sample,
// passing through four arithmetic stages, an eight-stage divider resolving
// two quotient bits each, and the output register. Throughput is one sample
// per clock; the whole pipe holds only while a finished result sits stalled
// at the output, and sample_stall follows that condition. The first sample
// after reset is paired with a previous sample of zero and yields 0.
module fm_phase_discriminator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic signed [15:0] sample_real,
	input  logic signed [15:0] sample_imag,
	output logic        phase_valid,
	input  logic        phase_stall,
	output logic signed [15:0] phase_delta
);

	localparam int SW = fmpd_pkg::SAMPLE_W;
	localparam int MW = fmpd_pkg::MAG_W;

	logic en;
	logic accept;

	logic [SW-1:0] prev_real_q, prev_imag_q;
	logic [SW-1:0] conj_imag;

	logic          valid_s1, valid_s2, valid_s3, valid_s4, valid_s6;
	logic [SW-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic [SW-1:0] pr_s2, pi_s2;
	logic [MW-1:0] mag_s3;
	logic [fmpd_pkg::DEN_W-1:0] den_s3;
	fmpd_pkg::fmpd_side_t side_s3;
	fmpd_pkg::fmpd_div_req_t req_s4;
	logic [SW-1:0] delta_s6;

	logic [MW-1:0] abs_im, abs_re;

	logic                    div_valid;
	fmpd_pkg::fmpd_div_rsp_t div_rsp;

	logic signed [fmpd_pkg::ANGLE_W-1:0] q_signed, t_val, angle;
	logic [SW-1:0] delta_d;

	function automatic logic [MW-1:0] sat_abs(input logic [SW-1:0] v);
		if (!v[SW-1])
			return v[MW-1:0];
		else if (v == {1'b1, {(SW-1){1'b0}}})
			return {MW{1'b1}};
		else
			return MW'(-v);
	endfunction

	assign en           = !(valid_s6 && phase_stall);
	assign sample_stall = !en;
	assign accept       = sample_valid && en;
	assign conj_imag    = -prev_imag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_real_q <= '0;
			prev_imag_q <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s6    <= 1'b0;
		end else begin
			if (accept) begin
				prev_real_q <= sample_real;
				prev_imag_q <= sample_imag;
			end
			if (en) begin
				valid_s1 <= sample_valid;
				valid_s2 <= valid_s1;
				valid_s3 <= valid_s2;
				valid_s4 <= valid_s3;
				valid_s6 <= div_valid;
			end
		end
	end

	// only the low 16 bits of each product are kept
	always_ff @(posedge clk) begin
		if (en) begin
			p_rr_s1 <= sample_real * prev_real_q;
			p_ii_s1 <= sample_imag * conj_imag;
			p_ri_s1 <= sample_real * conj_imag;
			p_ir_s1 <= sample_imag * prev_real_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s2 <= p_rr_s1 - p_ii_s1;
			pi_s2 <= p_ri_s1 + p_ir_s1;
		end
	end

	assign abs_im = sat_abs(pi_s2);
	assign abs_re = sat_abs(pr_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			den_s3           <= {1'b0, abs_im} + {1'b0, abs_re};
			mag_s3           <= (abs_im < abs_re) ? (abs_re - abs_im) : (abs_im - abs_re);
			side_s3.diff_neg <= abs_im < abs_re;
			side_s3.den_zero <= (abs_im == '0) && (abs_re == '0);
			side_s3.quad     <= fmpd_pkg::fmpd_quad_t'({pi_s2[SW-1], pr_s2[SW-1]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s4.num  <= {{(fmpd_pkg::NUM_W-MW){1'b0}}, mag_s3} * fmpd_pkg::ANG_NUM_SCALE;
			req_s4.den  <= den_s3;
			req_s4.side <= side_s3;
		end
	end

	fmpd_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.req_valid(valid_s4),
		.req      (req_s4),
		.rsp_valid(div_valid),
		.rsp      (div_rsp)
	);

	always_comb begin
		q_signed = div_rsp.side.diff_neg ? -$signed({1'b0, div_rsp.quot})
		                                 :  $signed({1'b0, div_rsp.quot});
		t_val    = q_signed >>> 3;	// floor toward minus infinity
		case (div_rsp.side.quad)
			fmpd_pkg::QUAD_1: angle = fmpd_pkg::ANG_EIGHTH + t_val;
			fmpd_pkg::QUAD_2: angle = fmpd_pkg::ANG_THREE_EIGHTHS - t_val;
			fmpd_pkg::QUAD_3: angle = t_val - fmpd_pkg::ANG_THREE_EIGHTHS;
			fmpd_pkg::QUAD_4: angle = -fmpd_pkg::ANG_EIGHTH - t_val;
			default:          angle = '0;
		endcase
		if (div_rsp.side.den_zero)
			delta_d = '0;
		else
			delta_d = SW'(-angle);
	end

	always_ff @(posedge clk) begin
		if (en)
			delta_s6 <= delta_d;
	end

	assign phase_valid = valid_s6;
	assign phase_delta = delta_s6;

endmodule

// ===== sv/fmpd_checker.sv =====
// ----------------------------------------------------------------------------
// fmpd_checker
// Port-level checks of the FM discriminator, bound to the top level.
// ----------------------------------------------------------------------------
module fmpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        sample_stall,
	input logic        phase_valid,
	input logic        phase_stall,
	input logic signed [15:0] phase_delta
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		phase_valid && phase_stall |=> phase_valid && $stable(phase_delta))
		else $error("stalled phase request changed");

	// pipe freezes exactly when the output is blocked
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall == (phase_valid && phase_stall))
		else $error("sample_stall does not track output backpressure");

	// angle stays within +-32766
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_valid |-> (phase_delta != 16'sh8000) && (phase_delta != 16'sh8001))
		else $error("phase_delta out of range");

	// nothing comes out in the first cycle after reset
	a_no_early: assert property (@(posedge clk)
		$rose(arst_n) |-> !phase_valid)
		else $error("phase request right after reset");

endmodule

bind fm_phase_discriminator fmpd_checker u_fmpd_checker (.*);
